// ----- rtl/rflf_pkg.sv -----
package rflf_pkg;

  // Default width of the frame length counter
  localparam int FRAME_LEN_BITS_DEF = 50;

  // Configuration register widths and reset values
  localparam int ARG_BITS  = 21;
  localparam int BULK_BITS = 30;
  localparam int CFG_DATA_BITS = 30;
  localparam logic [ARG_BITS-1:0]  MAX_ARG_COUNT_RST   = ARG_BITS'(1024 * 1024);
  localparam logic [BULK_BITS-1:0] MAX_BULK_LENGTH_RST = BULK_BITS'(512 * 1024 * 1024);

  // Register indexes on the configuration port
  typedef enum logic [0:0] {
    CFG_MAX_ARG_COUNT   = 1'b0,
    CFG_MAX_BULK_LENGTH = 1'b1
  } cfg_index_t;

  // Characters that steer the parser
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_STAR   = 8'd42;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_NINE   = 8'd57;

  // Two trailing bytes after every argument body
  localparam logic [BULK_BITS-1:0] TRAIL_BYTES = BULK_BITS'(2);

  // Result status codes
  typedef enum logic [0:0] {
    STAT_DONE      = 1'b0,
    STAT_MALFORMED = 1'b1
  } status_t;

  // Parser modes
  typedef enum logic [6:0] {
    MODE_IDLE      = 7'b0000001,
    MODE_INLINE    = 7'b0000010,
    MODE_COUNT     = 7'b0000100,
    MODE_ARG_START = 7'b0001000,
    MODE_ARG_LEN   = 7'b0010000,
    MODE_BODY      = 7'b0100000,
    MODE_TRAIL     = 7'b1000000
  } mode_t;

endpackage

// ----- rtl/rflf_if.sv -----
// Request byte channel
interface rflf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// Frame result channel
interface rflf_result_if #(
  parameter int FRAME_LEN_BITS = rflf_pkg::FRAME_LEN_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic                      status;
  logic                      is_array;
  logic [FRAME_LEN_BITS-1:0] frame_length;

  modport source (output valid, output status, output is_array, output frame_length,
                  input ready);
  modport sink   (input valid, input status, input is_array, input frame_length,
                  output ready);
endinterface

// ----- rtl/request_frame_length_finder.sv -----
// Request frame length finder.
// req carries the request stream, one byte per beat. rsp carries one beat per
// finished frame: status (0 complete, 1 malformed and abandoned), is_array and
// frame_length, the frame's byte count including its last byte, saturating at
// all ones. Inline frames end at the first CR LF; array frames ('*' count,
// then '$' length and body plus two trailing bytes per argument) end after
// their last argument. After a malformed byte, the next byte opens a new frame.
// Throughput: one byte per cycle while req.ready is high. Each byte updates
// the parser state in the cycle it is taken; a frame result shows on rsp in
// the next cycle unless one waits. Each step's limit is two adds, a compare.
// Results go into a two-entry output queue; req.ready drops only while both
// entries are full, so a stalled receiver holds back at most one more result.
// cfg_we/cfg_index/cfg_data write max_arg_count (index 0) and max_bulk_length
// (index 1); write them only while no frame is in progress.
// Reset (rst, synchronous) empties the queue, puts the parser at the start of
// a frame and sets the limits to 1048576 arguments and 536870912 body bytes.
module request_frame_length_finder #(
  parameter int FRAME_LEN_BITS = rflf_pkg::FRAME_LEN_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  rflf_pkg::cfg_index_t               cfg_index,
  input  logic [rflf_pkg::CFG_DATA_BITS-1:0] cfg_data,
  rflf_byte_if.sink                          req,
  rflf_result_if.source                      rsp
);
  import rflf_pkg::*;

  localparam int VAL_BITS = BULK_BITS + 4;

  // Configuration registers
  logic [ARG_BITS-1:0]  max_arg_count;
  logic [BULK_BITS-1:0] max_bulk_length;

  // Parser state
  mode_t                     mode, mode_next;
  logic                      prev_cr, prev_cr_next;
  logic [ARG_BITS-1:0]       args_left, args_left_next;
  logic [BULK_BITS-1:0]      acc, acc_next;
  logic [BULK_BITS-1:0]      body_left, body_left_next;
  logic [FRAME_LEN_BITS-1:0] frame_bytes, frame_bytes_next;

  // Output queue: head drives rsp, skid catches one more
  logic                      head_valid, skid_valid;
  logic                      head_status, skid_status;
  logic                      head_array, skid_array;
  logic [FRAME_LEN_BITS-1:0] head_len, skid_len;

  logic                      fire, pop, emit;
  logic                      emit_status, emit_array;
  logic [FRAME_LEN_BITS-1:0] frame_inc;
  logic [7:0]                b;
  logic                      is_digit;
  logic [BULK_BITS-1:0]      limit;
  logic [VAL_BITS-1:0]       val;
  logic                      num_bad, num_end, num_cr;
  logic [ARG_BITS-1:0]       args_dec;
  logic [BULK_BITS-1:0]      body_dec;

  assign req.ready = !skid_valid;
  assign fire      = req.valid && req.ready;
  assign pop       = head_valid && rsp.ready;

  assign rsp.valid        = head_valid;
  assign rsp.status       = head_status;
  assign rsp.is_array     = head_array;
  assign rsp.frame_length = head_len;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_arg_count   <= MAX_ARG_COUNT_RST;
      max_bulk_length <= MAX_BULK_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_ARG_COUNT:   max_arg_count   <= cfg_data[ARG_BITS-1:0];
        CFG_MAX_BULK_LENGTH: max_bulk_length <= cfg_data[BULK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Decimal digit step: val = acc * 10 + digit, checked against the active limit
  assign b        = req.data_byte;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign limit    = (mode == MODE_COUNT) ? BULK_BITS'(max_arg_count) : max_bulk_length;
  assign val      = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
                  + VAL_BITS'(b - CH_ZERO);
  assign num_end  = prev_cr && (b == CH_LF);
  assign num_cr   = !prev_cr && (b == CH_CR);
  assign num_bad  = prev_cr ? (b != CH_LF)
                            : ((b != CH_CR) && (!is_digit || (val > VAL_BITS'(limit))));

  assign frame_inc = (frame_bytes == {FRAME_LEN_BITS{1'b1}}) ? frame_bytes
                                                              : frame_bytes + 1'b1;
  assign args_dec  = args_left - 1'b1;
  assign body_dec  = body_left - 1'b1;

  // Parser next state for the byte on req
  always_comb begin
    mode_next        = mode;
    prev_cr_next     = prev_cr;
    args_left_next   = args_left;
    acc_next         = acc;
    body_left_next   = body_left;
    frame_bytes_next = frame_inc;
    emit             = 1'b0;
    emit_status      = STAT_DONE;
    emit_array       = 1'b1;

    unique case (mode)
      MODE_IDLE: begin
        acc_next = '0;
        if (b == CH_STAR) begin
          mode_next    = MODE_COUNT;
          prev_cr_next = 1'b0;
        end else begin
          mode_next    = MODE_INLINE;
          prev_cr_next = (b == CH_CR);
        end
      end
      MODE_INLINE: begin
        if (prev_cr && (b == CH_LF)) begin
          emit       = 1'b1;
          emit_array = 1'b0;
        end else begin
          prev_cr_next = (b == CH_CR);
        end
      end
      MODE_COUNT: begin
        if (num_bad) begin
          emit        = 1'b1;
          emit_status = STAT_MALFORMED;
        end else if (num_end) begin
          args_left_next = acc[ARG_BITS-1:0];
          if (acc[ARG_BITS-1:0] == '0) begin
            emit = 1'b1;
          end else begin
            mode_next    = MODE_ARG_START;
            prev_cr_next = 1'b0;
            acc_next     = '0;
          end
        end else if (num_cr) begin
          prev_cr_next = 1'b1;
        end else begin
          acc_next = val[BULK_BITS-1:0];
        end
      end
      MODE_ARG_START: begin
        if (b != CH_DOLLAR) begin
          emit        = 1'b1;
          emit_status = STAT_MALFORMED;
        end else begin
          mode_next    = MODE_ARG_LEN;
          prev_cr_next = 1'b0;
          acc_next     = '0;
        end
      end
      MODE_ARG_LEN: begin
        if (num_bad) begin
          emit        = 1'b1;
          emit_status = STAT_MALFORMED;
        end else if (num_end) begin
          prev_cr_next = 1'b0;
          acc_next     = '0;
          if (acc == '0) begin
            mode_next      = MODE_TRAIL;
            body_left_next = TRAIL_BYTES;
          end else begin
            mode_next      = MODE_BODY;
            body_left_next = acc;
          end
        end else if (num_cr) begin
          prev_cr_next = 1'b1;
        end else begin
          acc_next = val[BULK_BITS-1:0];
        end
      end
      MODE_BODY: begin
        if (body_dec == '0) begin
          mode_next      = MODE_TRAIL;
          body_left_next = TRAIL_BYTES;
        end else begin
          body_left_next = body_dec;
        end
      end
      MODE_TRAIL: begin
        body_left_next = body_dec;
        if (body_dec == '0) begin
          args_left_next = args_dec;
          if (args_dec == '0) begin
            emit = 1'b1;
          end else begin
            mode_next    = MODE_ARG_START;
            prev_cr_next = 1'b0;
            acc_next     = '0;
          end
        end
      end
      default: begin
        mode_next        = MODE_IDLE;
        prev_cr_next     = 1'b0;
        args_left_next   = '0;
        acc_next         = '0;
        body_left_next   = '0;
        frame_bytes_next = '0;
      end
    endcase

    // A reported frame leaves the parser at the start of the next one
    if (emit) begin
      mode_next        = MODE_IDLE;
      prev_cr_next     = 1'b0;
      args_left_next   = '0;
      acc_next         = '0;
      body_left_next   = '0;
      frame_bytes_next = '0;
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      prev_cr     <= 1'b0;
      args_left   <= '0;
      acc         <= '0;
      body_left   <= '0;
      frame_bytes <= '0;
    end else if (fire) begin
      mode        <= mode_next;
      prev_cr     <= prev_cr_next;
      args_left   <= args_left_next;
      acc         <= acc_next;
      body_left   <= body_left_next;
      frame_bytes <= frame_bytes_next;
    end
  end

  // Output queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        head_valid <= fire && emit;
      end
    end else if (fire && emit) begin
      if (head_valid) begin
        skid_valid <= 1'b1;
      end else begin
        head_valid <= 1'b1;
      end
    end
  end

  // Output queue payload
  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      head_status <= skid_status;
      head_array  <= skid_array;
      head_len    <= skid_len;
    end else if (fire && emit && (pop || !head_valid)) begin
      head_status <= emit_status;
      head_array  <= emit_array;
      head_len    <= frame_inc;
    end
    if (fire && emit && head_valid && !pop) begin
      skid_status <= emit_status;
      skid_array  <= emit_array;
      skid_len    <= frame_inc;
    end
  end

  // The skid entry is only ever filled behind a full head
  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> head_valid)
    else $error("skid entry valid without head entry");

  // A reported frame restarts the parser with an empty count
  a_emit_restarts: assert property (@(posedge clk) disable iff (rst)
    (fire && emit) |=> ((mode == MODE_IDLE) && (frame_bytes == '0)))
    else $error("parser not restarted after a frame result");

  // Body bytes are counted down to the trailer, never past zero
  a_body_nonzero: assert property (@(posedge clk) disable iff (rst)
    ((mode == MODE_BODY) || (mode == MODE_TRAIL)) |-> (body_left != '0))
    else $error("body counter empty inside an argument");

  // An argument is only opened while arguments remain
  a_args_nonzero: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_ARG_START) |-> (args_left != '0))
    else $error("argument opened with none left");

endmodule

// ----- tb/request_frame_length_finder_tb.sv -----
module request_frame_length_finder_tb;
  import rflf_pkg::*;

  localparam int LEN_BITS = FRAME_LEN_BITS_DEF;
  localparam logic [7:0] CH_JUNK = 8'h78;  // 'x': never a digit, CR, LF or marker
  localparam int PHASE_BYTES = 200;

  typedef enum {DIGITS_MORE, DIGITS_DONE, DIGITS_BAD} digit_step_t;

  typedef struct {
    status_t             status;
    logic                is_array;
    logic [LEN_BITS-1:0] length;
  } frame_result_t;

  // Framing predictor plus the queue of frame results still owed by the block
  class frame_scoreboard;
    logic [ARG_BITS-1:0]  arg_limit;
    logic [BULK_BITS-1:0] bulk_limit;
    mode_t                mode;
    bit                   prev_cr;
    logic [ARG_BITS-1:0]  args_left;
    logic [63:0]          accum;
    logic [BULK_BITS-1:0] body_left;
    logic [LEN_BITS-1:0]  frame_bytes;
    frame_result_t        owed_q[$];
    int                   errors;

    function void go_idle();
      mode = MODE_IDLE;
      prev_cr = 1'b0;
      args_left = '0;
      accum = '0;
      body_left = '0;
      frame_bytes = '0;
    endfunction

    function void reset();
      arg_limit = MAX_ARG_COUNT_RST;
      bulk_limit = MAX_BULK_LENGTH_RST;
      errors = 0;
      go_idle();
    endfunction

    function void set_limit(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] value);
      if (idx == CFG_MAX_ARG_COUNT) arg_limit = value[ARG_BITS-1:0];
      else bulk_limit = value[BULK_BITS-1:0];
    endfunction

    function void finish_frame(status_t st, logic arr);
      frame_result_t r;
      r.status = st;
      r.is_array = arr;
      r.length = frame_bytes;
      owed_q.push_back(r);
      go_idle();
    endfunction

    // One byte of a CR LF terminated decimal number
    function digit_step_t digit_step(logic [7:0] b, logic [63:0] limit);
      logic [63:0] v;
      if (prev_cr) return (b == CH_LF) ? DIGITS_DONE : DIGITS_BAD;
      if (b == CH_CR) begin
        prev_cr = 1'b1;
        return DIGITS_MORE;
      end
      if (b < CH_ZERO || b > CH_NINE) return DIGITS_BAD;
      v = accum * 64'd10 + 64'(b - CH_ZERO);
      if (v > limit) return DIGITS_BAD;
      accum = v;
      return DIGITS_MORE;
    endfunction

    function void next_arg();
      if (args_left == 0) begin
        finish_frame(STAT_DONE, 1'b1);
      end else begin
        mode = MODE_ARG_START;
        prev_cr = 1'b0;
        accum = '0;
      end
    endfunction

    // Advance the parser by one accepted request byte
    function void note_byte(logic [7:0] b);
      digit_step_t r;
      if (frame_bytes != '1) frame_bytes++;
      case (mode)
        MODE_IDLE: begin
          accum = '0;
          if (b == CH_STAR) begin
            mode = MODE_COUNT;
            prev_cr = 1'b0;
          end else begin
            mode = MODE_INLINE;
            prev_cr = (b == CH_CR);
          end
        end
        MODE_INLINE: begin
          if (prev_cr && b == CH_LF) finish_frame(STAT_DONE, 1'b0);
          else prev_cr = (b == CH_CR);
        end
        MODE_COUNT: begin
          r = digit_step(b, 64'(arg_limit));
          if (r == DIGITS_BAD) begin
            finish_frame(STAT_MALFORMED, 1'b1);
          end else if (r == DIGITS_DONE) begin
            args_left = accum[ARG_BITS-1:0];
            next_arg();
          end
        end
        MODE_ARG_START: begin
          if (b != CH_DOLLAR) begin
            finish_frame(STAT_MALFORMED, 1'b1);
          end else begin
            mode = MODE_ARG_LEN;
            prev_cr = 1'b0;
            accum = '0;
          end
        end
        MODE_ARG_LEN: begin
          r = digit_step(b, 64'(bulk_limit));
          if (r == DIGITS_BAD) begin
            finish_frame(STAT_MALFORMED, 1'b1);
          end else if (r == DIGITS_DONE) begin
            prev_cr = 1'b0;
            body_left = accum[BULK_BITS-1:0];
            accum = '0;
            if (body_left == 0) begin
              mode = MODE_TRAIL;
              body_left = TRAIL_BYTES;
            end else begin
              mode = MODE_BODY;
            end
          end
        end
        MODE_BODY: begin
          body_left--;
          if (body_left == 0) begin
            mode = MODE_TRAIL;
            body_left = TRAIL_BYTES;
          end
        end
        MODE_TRAIL: begin
          body_left--;
          if (body_left == 0) begin
            args_left--;
            next_arg();
          end
        end
        default: go_idle();
      endcase
    endfunction

    // Compare one result beat against the oldest owed frame
    function void check_result(logic st, logic arr, logic [LEN_BITS-1:0] len);
      frame_result_t e;
      if (owed_q.size() == 0) begin
        $error("result beat with no frame owed: status %0d is_array %0d frame_length %0d",
               st, arr, len);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (arr !== e.is_array) begin
        $error("is_array: expected %0d, got %0d", e.is_array, arr);
        errors++;
      end
      if (len !== e.length) begin
        $error("frame_length: expected %0d, got %0d", e.length, len);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  cfg_index_t cfg_index = CFG_MAX_ARG_COUNT;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  rflf_byte_if req_if ();
  rflf_result_if #(.FRAME_LEN_BITS(LEN_BITS)) rsp_if ();

  request_frame_length_finder #(.FRAME_LEN_BITS(LEN_BITS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  frame_scoreboard sb = new();
  logic [7:0] frame_q[$];
  bit tx_fast = 1'b0;
  bit rx_fast = 1'b0;
  int hold_cycles = 0;

  always #5 clk = ~clk;

  // Run guard
  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

  // Result receiver: random stalls, burst stretches, and one long hold on request
  initial begin
    int stall;
    int beats;
    beats = 0;
    rsp_if.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (hold_cycles > 0) begin
        repeat (hold_cycles) @(negedge clk) rsp_if.ready = 1'b0;
        hold_cycles = 0;
      end
      stall = rx_fast ? 0 : $urandom_range(0, 8);
      repeat (stall) @(negedge clk) rsp_if.ready = 1'b0;
      @(negedge clk) rsp_if.ready = 1'b1;
      do @(posedge clk); while (rsp_if.valid !== 1'b1);
      sb.check_result(rsp_if.status, rsp_if.is_array, rsp_if.frame_length);
      beats++;
      if (beats % 16 == 0) rx_fast = ($urandom_range(0, 3) == 0);
    end
  end

  // Offer one request byte after a random gap and wait for the beat
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 8);
    repeat (gap) @(negedge clk) req_if.valid = 1'b0;
    @(negedge clk);
    req_if.valid = 1'b1;
    req_if.data_byte = b;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    sb.note_byte(b);
  endtask

  task automatic send_frame();
    tx_fast = ($urandom_range(0, 3) == 0);
    foreach (frame_q[i]) send_byte(frame_q[i]);
    frame_q.delete();
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endtask

  task automatic send_text(string s);
    add_text(s);
    send_frame();
  endtask

  // Decimal number with CR LF; zero is sometimes left empty, leading zero sometimes
  task automatic add_number(longint unsigned n);
    if (n == 0 && $urandom_range(0, 2) == 0) begin
      add_text("\015\n");
    end else begin
      if ($urandom_range(0, 5) == 0) add_text("0");
      add_text($sformatf("%0d\015\n", n));
    end
  endtask

  task automatic drain_results();
    @(negedge clk) req_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Bring the parser back to a frame start, collect all results, let the block settle
  task automatic settle();
    while (sb.mode != MODE_IDLE) begin
      if (sb.mode == MODE_INLINE) send_byte(sb.prev_cr ? CH_LF : CH_CR);
      else send_byte(CH_JUNK);
    end
    drain_results();
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(cfg_index_t idx, int unsigned value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_DATA_BITS'(value);
    sb.set_limit(idx, CFG_DATA_BITS'(value));
    @(negedge clk) cfg_we = 1'b0;
  endtask

  // One random frame: mostly well formed, some corrupted, over limit or noise
  task automatic build_random_frame();
    int kind;
    int arg_cap;
    int bulk_cap;
    int nargs;
    int len;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    arg_cap = (sb.arg_limit < 4) ? int'(sb.arg_limit) : 4;
    bulk_cap = (sb.bulk_limit < 10) ? int'(sb.bulk_limit) : 10;
    if (kind < 25) begin
      do b = 8'($urandom_range(0, 255)); while (b == CH_STAR);
      frame_q.push_back(b);
      repeat ($urandom_range(0, 8)) begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_CR);
        frame_q.push_back(b);
      end
      add_text("\015\n");
    end else if (kind < 88) begin
      nargs = $urandom_range(0, arg_cap);
      frame_q.push_back(CH_STAR);
      add_number(nargs);
      repeat (nargs) begin
        len = $urandom_range(0, bulk_cap);
        frame_q.push_back(CH_DOLLAR);
        add_number(len);
        repeat (len + 2) frame_q.push_back(8'($urandom_range(0, 255)));
      end
      // corrupt one byte of the frame
      if (kind >= 72) frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (kind < 95) begin
      frame_q.push_back(CH_STAR);
      if ($urandom_range(0, 1) == 0) begin
        add_text($sformatf("%0d", 64'(sb.arg_limit) + 1));
      end else begin
        add_text("1\015\n$");
        add_text($sformatf("%0d", 64'(sb.bulk_limit) + 1));
      end
    end else begin
      repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random_phase(int phase);
    int sent;
    sent = 0;
    if (phase == 0) hold_cycles = 400;
    while (sent < PHASE_BYTES) begin
      build_random_frame();
      sent += frame_q.size();
      send_frame();
      if (phase == 1 && sent >= PHASE_BYTES / 2 && sent < PHASE_BYTES / 2 + 20) drain_results();
    end
  endtask

  // Stimulus
  initial begin
    int waited;
    req_if.valid = 1'b0;
    req_if.data_byte = '0;
    sb.reset();
    repeat (11) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // Reset limits: inline frames, array frames and malformed cases
    send_text("PING\015\n");
    send_text("\015\n");
    send_text("a\015b\015\n");
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'h00);
    send_text("\015\n");
    send_text("*1\015\n$3\015\nSET\015\n");
    send_text("*0\015\n");
    send_text("*\015\n");
    send_text("*2\015\n$0\015\n\015\n$\015\nzz");
    add_text("*1\015\n$2\015\n");
    frame_q.push_back(8'h00);
    frame_q.push_back(8'hFF);
    send_text("\015\n");
    send_text("*1\015\n$2\015\n\015\n\015\n");
    send_text("*1\015x");
    send_text("*1\n");
    send_text("*1a");
    send_text("*1\015\n#");
    send_text("*1048577");
    send_text("*1048576\015\nx");
    send_text("*1\015\n$536870913");
    send_text("*1\015\n$536870912x");
    settle();

    // Both limits at zero
    write_limit(CFG_MAX_ARG_COUNT, 0);
    write_limit(CFG_MAX_BULK_LENGTH, 0);
    send_text("*\015\n");
    send_text("*00\015\n");
    send_text("*1");
    settle();

    // Count limit at its reset value, empty bodies only
    write_limit(CFG_MAX_ARG_COUNT, 1048576);
    send_text("*2\015\n$0\015\nab$\015\ncd");
    send_text("*1\015\n$1");
    settle();

    // Both limits at their reset values
    write_limit(CFG_MAX_BULK_LENGTH, 536870912);
    send_text("*1048576\015\n$1\015\na\015\n");
    settle();
    send_text("*1\015\n$536870913");
    settle();

    // Random frames under several limit settings
    write_limit(CFG_MAX_ARG_COUNT, 1048576);
    write_limit(CFG_MAX_BULK_LENGTH, 40);
    run_random_phase(0);
    settle();
    write_limit(CFG_MAX_ARG_COUNT, 3);
    write_limit(CFG_MAX_BULK_LENGTH, 6);
    run_random_phase(1);
    settle();
    write_limit(CFG_MAX_ARG_COUNT, $urandom_range(0, 12));
    write_limit(CFG_MAX_BULK_LENGTH, $urandom_range(0, 64));
    run_random_phase(2);
    settle();
    write_limit(CFG_MAX_ARG_COUNT, 8);
    write_limit(CFG_MAX_BULK_LENGTH, 1);
    run_random_phase(3);

    // Wind down
    @(negedge clk) req_if.valid = 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d frame results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
